### design/assert_macros.svh
// Assertion macros shared by the button and touch qualifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### design/btq_pkg.sv
// Types and constants of the button and touch event qualifier.
package btq_pkg;

   // Item modes.
   localparam logic [2:0] MODE_POLL       = 3'd0;
   localparam logic [2:0] MODE_TAKE_TAP   = 3'd1;
   localparam logic [2:0] MODE_TAKE_CLICK = 3'd2;
   localparam logic [2:0] MODE_TAKE_LONG  = 3'd3;
   localparam logic [2:0] MODE_TAKE_ANY   = 3'd4;
   localparam logic [2:0] MODE_DISCARD    = 3'd5;
   localparam logic [2:0] MODE_PAUSE      = 3'd6;

   // Register indexes, taken from the word address.
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;
   localparam logic [1:0] REG_TOUCH_EN   = 2'd2;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [7:0]  DEBOUNCE_RESET   = 8'd30;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic        TOUCH_EN_RESET   = 1'b0;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] now_ms;
      logic        button_pressed;
      logic        touch_down;
      logic [11:0] touch_x;
      logic [11:0] touch_y;
      logic [15:0] pause_ms;
   } req_payload_type;

   typedef struct packed {
      logic        event_found;
      logic [11:0] tap_x;
      logic [11:0] tap_y;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  debounce_ms;
      logic [15:0] long_press_ms;
      logic        touch_enabled;
   } cfg_type;

endpackage

### design/button_touch_event_qualifier_core.sv
// Top level of the button and touch event qualifier.
//
// Accepts one item per clock cycle when the result side does not stall and returns
// exactly one result beat per item. An accepted item waits in an input register;
// once the output register is empty or being drained, the event state is updated in one pass of
// compares and flag logic, and the result lands in an output register, so a new item
// can be taken while a finished result is still waiting. The one-pass update of
// the event state sets the rate. Configuration registers sit at byte addresses 0
// (debounce, ms), 4 (long press threshold, ms) and 8 (touch enable) and are to be
// written only while the block is idle.
`include "assert_macros.svh"

module button_touch_event_qualifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  btq_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output btq_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [btq_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [btq_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [btq_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   btq_pkg::cfg_type         cfg;
   btq_pkg::req_payload_type in_item_ff;
   btq_pkg::rsp_payload_type result;
   btq_pkg::rsp_payload_type rsp_payload_ff;
   logic                     in_valid_ff, in_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     advance;
   logic                     req_take;

   btq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btq_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // The held item moves on whenever the output register is empty or being drained.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)

   `ASSERT_NEXT(a_step_gives_beat, clock, reset, advance, rsp_valid_ff)

   `ASSERT_NEXT(a_poll_finds_nothing, clock, reset, advance && (in_item_ff.mode == btq_pkg::MODE_POLL), !rsp_payload_ff.event_found)

endmodule

### design/btq_csr.sv
// Configuration registers of the qualifier behind an APB-style port.
module btq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [btq_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [btq_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [btq_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output btq_pkg::cfg_type                     cfg
);

   btq_pkg::cfg_type cfg_ff, cfg_in;
   logic             write_en;
   logic [1:0]       reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            btq_pkg::REG_DEBOUNCE:   cfg_in.debounce_ms   = csr_pwdata[7:0];
            btq_pkg::REG_LONG_PRESS: cfg_in.long_press_ms = csr_pwdata[15:0];
            btq_pkg::REG_TOUCH_EN:   cfg_in.touch_enabled = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         btq_pkg::REG_DEBOUNCE:   csr_prdata[7:0]  = cfg_ff.debounce_ms;
         btq_pkg::REG_LONG_PRESS: csr_prdata[15:0] = cfg_ff.long_press_ms;
         btq_pkg::REG_TOUCH_EN:   csr_prdata[0]    = cfg_ff.touch_enabled;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= btq_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= btq_pkg::LONG_PRESS_RESET;
         cfg_ff.touch_enabled <= btq_pkg::TOUCH_EN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/btq_engine.sv
// Event state of the qualifier and its combinational update for one item.
`include "assert_macros.svh"

module btq_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  btq_pkg::req_payload_type item,
   input  btq_pkg::cfg_type         cfg,
   output btq_pkg::rsp_payload_type result
);

   logic        button_level_ff, button_level_in;
   logic [31:0] last_change_ff, last_change_in;
   logic [31:0] press_start_ff, press_start_in;
   logic        click_pending_ff, click_pending_in;
   logic        long_pending_ff, long_pending_in;
   logic        touch_active_ff, touch_active_in;
   logic        tap_pending_ff, tap_pending_in;
   logic [11:0] last_x_ff, last_x_in;
   logic [11:0] last_y_ff, last_y_in;
   logic [31:0] pause_end_ff, pause_end_in;

   logic [31:0] since_change;
   logic [31:0] press_len;
   logic [31:0] since_pause_end;
   logic        button_ok;
   logic        is_long;
   logic        touch_live;

   assign since_change    = item.now_ms - last_change_ff;
   assign press_len       = item.now_ms - press_start_ff;
   assign since_pause_end = item.now_ms - pause_end_ff;

   // A level change counts only once the debounce window has run out.
   assign button_ok  = (item.button_pressed != button_level_ff) &&
                       (since_change >= {24'd0, cfg.debounce_ms});
   assign is_long    = press_len >= {16'd0, cfg.long_press_ms};
   // The pause end is compared with wrap: a negative distance means still paused.
   assign touch_live = cfg.touch_enabled && !since_pause_end[31];

   always_comb begin
      button_level_in  = button_level_ff;
      last_change_in   = last_change_ff;
      press_start_in   = press_start_ff;
      click_pending_in = click_pending_ff;
      long_pending_in  = long_pending_ff;
      touch_active_in  = touch_active_ff;
      tap_pending_in   = tap_pending_ff;
      last_x_in        = last_x_ff;
      last_y_in        = last_y_ff;
      pause_end_in     = pause_end_ff;
      result           = '0;
      case (item.mode)
         btq_pkg::MODE_POLL: begin
            if (button_ok) begin
               last_change_in  = item.now_ms;
               button_level_in = item.button_pressed;
               if (item.button_pressed) begin
                  press_start_in = item.now_ms;
               end else if (is_long) begin
                  long_pending_in = 1'b1;
               end else begin
                  click_pending_in = 1'b1;
               end
            end
            if (touch_live) begin
               if (item.touch_down) begin
                  last_x_in       = item.touch_x;
                  last_y_in       = item.touch_y;
                  touch_active_in = 1'b1;
               end else if (touch_active_ff) begin
                  touch_active_in = 1'b0;
                  tap_pending_in  = 1'b1;
               end
            end
         end
         btq_pkg::MODE_TAKE_TAP: begin
            if (tap_pending_ff) begin
               tap_pending_in     = 1'b0;
               result.event_found = 1'b1;
               result.tap_x       = last_x_ff;
               result.tap_y       = last_y_ff;
            end
         end
         btq_pkg::MODE_TAKE_CLICK: begin
            result.event_found = click_pending_ff;
            click_pending_in   = 1'b0;
         end
         btq_pkg::MODE_TAKE_LONG: begin
            result.event_found = long_pending_ff;
            long_pending_in    = 1'b0;
         end
         btq_pkg::MODE_TAKE_ANY: begin
            result.event_found = tap_pending_ff | click_pending_ff | long_pending_ff;
            tap_pending_in     = 1'b0;
            click_pending_in   = 1'b0;
            long_pending_in    = 1'b0;
         end
         btq_pkg::MODE_DISCARD: begin
            tap_pending_in   = 1'b0;
            click_pending_in = 1'b0;
            long_pending_in  = 1'b0;
         end
         btq_pkg::MODE_PAUSE: begin
            pause_end_in    = item.now_ms + {16'd0, item.pause_ms};
            touch_active_in = 1'b0;
            tap_pending_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_level_ff  <= 1'b0;
         last_change_ff   <= '0;
         press_start_ff   <= '0;
         click_pending_ff <= 1'b0;
         long_pending_ff  <= 1'b0;
         touch_active_ff  <= 1'b0;
         tap_pending_ff   <= 1'b0;
         last_x_ff        <= '0;
         last_y_ff        <= '0;
         pause_end_ff     <= '0;
      end else if (step) begin
         button_level_ff  <= button_level_in;
         last_change_ff   <= last_change_in;
         press_start_ff   <= press_start_in;
         click_pending_ff <= click_pending_in;
         long_pending_ff  <= long_pending_in;
         touch_active_ff  <= touch_active_in;
         tap_pending_ff   <= tap_pending_in;
         last_x_ff        <= last_x_in;
         last_y_ff        <= last_y_in;
         pause_end_ff     <= pause_end_in;
      end
   end

   `ASSERT_NEXT(a_take_any_clears, clock, reset, step && (item.mode == btq_pkg::MODE_TAKE_ANY), !tap_pending_ff && !click_pending_ff && !long_pending_ff)

   `ASSERT_NEXT(a_pause_drops_touch, clock, reset, step && (item.mode == btq_pkg::MODE_PAUSE), !touch_active_ff && !tap_pending_ff)

endmodule
